// File: rtl/lspt_pkg.sv
// Package for the line sensor position tracker.
// Holds widths, register indexes, reset values and the payload structs.
// No dependencies.
package lspt_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int NUM_SENSORS    = 8;
  localparam int STEER_BITS     = 14;
  localparam int COUNT_BITS     = 4;
  localparam int OFFSET_BITS    = 10;
  localparam int MIN_SUM_BITS   = 13;
  localparam int WIDE_BITS      = 4;
  localparam int DRIVE_BITS     = 10;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int SUM_BITS       = SAMPLE_BITS + 3;
  localparam int ERR_BITS       = SAMPLE_BITS + 4;
  localparam int STEER_MAX      = 8191;
  localparam int STEER_MIN      = -8192;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SENSOR_OFFSET     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECOVER_MIN_SUM   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE_ACTIVE_COUNT = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOST_DRIVE        = 2'd3;

  localparam logic [OFFSET_BITS-1:0]  RST_SENSOR_OFFSET     = 10'd900;
  localparam logic [MIN_SUM_BITS-1:0] RST_RECOVER_MIN_SUM   = 13'd150;
  localparam logic [WIDE_BITS-1:0]    RST_WIDE_ACTIVE_COUNT = 4'd5;
  localparam logic [DRIVE_BITS-1:0]   RST_LOST_DRIVE        = 10'd500;

  typedef logic [SAMPLE_BITS-1:0] sample_word_t;

  typedef struct packed {
    sample_word_t sample_0;
    sample_word_t sample_1;
    sample_word_t sample_2;
    sample_word_t sample_3;
    sample_word_t sample_4;
    sample_word_t sample_5;
    sample_word_t sample_6;
    sample_word_t sample_7;
  } sample_t;

  typedef struct packed {
    logic signed [STEER_BITS-1:0] steer_error;
    logic                         lost_line;
    logic                         heading_right;
    logic [COUNT_BITS-1:0]        active_count;
  } result_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]  sensor_offset;
    logic [MIN_SUM_BITS-1:0] recover_min_sum;
    logic [WIDE_BITS-1:0]    wide_active_count;
    logic [DRIVE_BITS-1:0]   lost_drive;
  } cfg_t;

  typedef struct packed {
    logic signed [STEER_BITS-1:0] error;
    logic [COUNT_BITS-1:0]        count;
    logic [SUM_BITS-1:0]          level_sum;
    logic                         center_dark;
    logic                         edge_left;
    logic                         edge_right;
  } features_t;

endpackage

// File: rtl/lspt_features.sv
// Offset removal, active count, level sum and saturated weighted error.
// Pure combinational; depends on lspt_pkg.
module lspt_features (
  input  lspt_pkg::sample_t   sample,
  input  lspt_pkg::cfg_t      cfg,
  output lspt_pkg::features_t features
);
  import lspt_pkg::*;

  localparam int DW = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
  localparam int CW = (ERR_BITS > STEER_BITS) ? ERR_BITS : STEER_BITS;
  localparam logic signed [CW-1:0] SAT_HI = CW'(STEER_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(STEER_MIN);

  sample_word_t          raw   [NUM_SENSORS];
  sample_word_t          level [NUM_SENSORS];
  logic [DW-1:0]         diff  [NUM_SENSORS];
  logic [SUM_BITS-1:0]   sum;
  logic [COUNT_BITS-1:0] count;
  logic signed [ERR_BITS-1:0] err;
  logic signed [CW-1:0]       err_w;
  logic signed [CW-1:0]       err_sat;

  assign raw[0] = sample.sample_0;
  assign raw[1] = sample.sample_1;
  assign raw[2] = sample.sample_2;
  assign raw[3] = sample.sample_3;
  assign raw[4] = sample.sample_4;
  assign raw[5] = sample.sample_5;
  assign raw[6] = sample.sample_6;
  assign raw[7] = sample.sample_7;

  always_comb begin
    sum   = '0;
    count = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      diff[i]  = DW'(raw[i]) - DW'(cfg.sensor_offset);
      level[i] = diff[i][DW-1] ? '0 : diff[i][SAMPLE_BITS-1:0];
      sum      = sum + SUM_BITS'(level[i]);
      count    = count + COUNT_BITS'(level[i] != '0);
    end
  end

  always_comb begin
    err = $signed(ERR_BITS'(level[0]) + ERR_BITS'(level[0]) + ERR_BITS'(level[0]))
        + $signed(ERR_BITS'(level[1]) + ERR_BITS'(level[1]))
        + $signed(ERR_BITS'(level[2]))
        - $signed(ERR_BITS'(level[5]))
        - $signed(ERR_BITS'(level[6]) + ERR_BITS'(level[6]))
        - $signed(ERR_BITS'(level[7]) + ERR_BITS'(level[7]) + ERR_BITS'(level[7]));
    err_w = CW'(err);
    if (err_w > SAT_HI) begin
      err_sat = SAT_HI;
    end else if (err_w < SAT_LO) begin
      err_sat = SAT_LO;
    end else begin
      err_sat = err_w;
    end
  end

  assign features.error       = err_sat[STEER_BITS-1:0];
  assign features.count       = count;
  assign features.level_sum   = sum;
  assign features.center_dark = (level[3] == '0) || (level[4] == '0);
  assign features.edge_left   = level[0] != '0;
  assign features.edge_right  = level[NUM_SENSORS-1] != '0;

endmodule

// File: rtl/lspt_track.sv
// Lost-line flag and heading state, and the steering output selection.
// State advances once per transaction; depends on lspt_pkg.
module lspt_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  lspt_pkg::features_t features,
  input  lspt_pkg::cfg_t      cfg,
  output lspt_pkg::result_t   result
);
  import lspt_pkg::*;

  localparam int MW = (SUM_BITS > MIN_SUM_BITS) ? SUM_BITS : MIN_SUM_BITS;

  logic lost_flag;
  logic direction;
  logic lost_flag_next;
  logic direction_next;
  logic lose;
  logic lost_now;
  logic in_window;
  logic edge_seen;
  logic sum_ok;
  logic signed [STEER_BITS-1:0] drive;
  logic signed [STEER_BITS-1:0] steer;

  assign drive = $signed(STEER_BITS'(cfg.lost_drive));

  always_comb begin
    lose      = (features.center_dark && (features.error == '0))
             || (features.count >= cfg.wide_active_count);
    lost_now  = lost_flag || lose;
    in_window = (features.count == COUNT_BITS'(1)) || (features.count == COUNT_BITS'(2));
    sum_ok    = MW'(features.level_sum) >= MW'(cfg.recover_min_sum);
    edge_seen = direction ? features.edge_right : features.edge_left;
    direction_next = direction;
    if (!lost_now) begin
      lost_flag_next = 1'b0;
      steer          = features.error;
      if (features.error > 0) begin
        direction_next = 1'b0;
      end else if (features.error < 0) begin
        direction_next = 1'b1;
      end
    end else begin
      lost_flag_next = !(in_window && (sum_ok || edge_seen));
      steer          = direction ? -drive : drive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lost_flag <= 1'b0;
      direction <= 1'b0;
    end else if (advance) begin
      lost_flag <= lost_flag_next;
      direction <= direction_next;
    end
  end

  assign result.steer_error   = steer;
  assign result.lost_line     = lost_flag_next;
  assign result.heading_right = direction_next;
  assign result.active_count  = features.count;

endmodule

// File: rtl/line_sensor_position_tracker.sv
// Top level of the line sensor position tracker: config registers, input and result registers.
// Instantiates lspt_features and lspt_track; depends on lspt_pkg.
//
// Takes one set of eight line-sensor samples per transaction and returns one result per set:
// the saturated weighted position error (or the signed lost drive while the line is lost),
// the lost flag, the remembered heading and the active sensor count. One set is accepted
// every cycle unless result_stall holds the result register full; each set is held in the input
// register and its result in the result register. The lost flag and heading update as each set
// leaves the input register, so consecutive sets see the state left by the one before.
// Configuration writes take effect at once and are meant to happen while the block is idle.
module line_sensor_position_tracker (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [lspt_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [lspt_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                     sample_valid,
  output logic                                     sample_stall,
  input  lspt_pkg::sample_t                        sample,
  output logic                                     result_valid,
  input  logic                                     result_stall,
  output lspt_pkg::result_t                        result
);
  import lspt_pkg::*;

  cfg_t      cfg;
  logic      held_valid;
  sample_t   held;
  logic      advance;
  features_t features;
  result_t   result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sensor_offset     <= RST_SENSOR_OFFSET;
      cfg.recover_min_sum   <= RST_RECOVER_MIN_SUM;
      cfg.wide_active_count <= RST_WIDE_ACTIVE_COUNT;
      cfg.lost_drive        <= RST_LOST_DRIVE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SENSOR_OFFSET:     cfg.sensor_offset     <= cfg_data[OFFSET_BITS-1:0];
        REG_RECOVER_MIN_SUM:   cfg.recover_min_sum   <= cfg_data[MIN_SUM_BITS-1:0];
        REG_WIDE_ACTIVE_COUNT: cfg.wide_active_count <= cfg_data[WIDE_BITS-1:0];
        REG_LOST_DRIVE:        cfg.lost_drive        <= cfg_data[DRIVE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign advance      = held_valid && (!result_valid || !result_stall);
  assign sample_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      held <= sample;
    end
  end

  lspt_features u_features (
    .sample   (held),
    .cfg      (cfg),
    .features (features)
  );

  lspt_track u_track (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .features (features),
    .cfg      (cfg),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// File: sim/line_sensor_position_tracker_tb.sv
// Testbench for line_sensor_position_tracker: directed and random sensor sets under several
// register settings, with a local steering tracker predicting every result.
// Depends on lspt_pkg and the line_sensor_position_tracker RTL.
module line_sensor_position_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lspt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam sample_word_t FULL   = 10'd1023;
  localparam sample_word_t ZERO   = 10'd0;
  localparam sample_word_t AT_OFS = 10'd900;
  localparam sample_word_t ABOVE  = 10'd901;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  // local copy of the registers and tracking state
  logic [OFFSET_BITS-1:0]  cfg_offset   = RST_SENSOR_OFFSET;
  logic [MIN_SUM_BITS-1:0] cfg_min_sum  = RST_RECOVER_MIN_SUM;
  logic [WIDE_BITS-1:0]    cfg_wide     = RST_WIDE_ACTIVE_COUNT;
  logic [DRIVE_BITS-1:0]   cfg_drive    = RST_LOST_DRIVE;
  logic                    track_lost   = 1'b0;
  logic                    track_right  = 1'b0;

  sample_t sensor_sets[$];
  result_t steering_due[$];
  logic sample_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 8;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;
  int line_pos = 3;
  int mismatch_count = 0;
  int cycle_count = 0;

  line_sensor_position_tracker u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #1 clk = ~clk;

  function automatic result_t next_steering(input sample_t s);
    sample_word_t raw [8];
    int level [8];
    int level_sum;
    int weighted;
    int steer;
    int unsigned active;
    logic in_window;
    result_t r;
    raw = '{s.sample_0, s.sample_1, s.sample_2, s.sample_3,
            s.sample_4, s.sample_5, s.sample_6, s.sample_7};
    level_sum = 0;
    active = 0;
    for (int i = 0; i < 8; i++) begin
      level[i] = int'(raw[i]) - int'(cfg_offset);
      if (level[i] < 0) level[i] = 0;
      level_sum += level[i];
      if (level[i] != 0) active++;
    end
    weighted = 3 * level[0] + 2 * level[1] + level[2] - level[5] - 2 * level[6] - 3 * level[7];
    if (weighted > STEER_MAX) weighted = STEER_MAX;
    if (weighted < STEER_MIN) weighted = STEER_MIN;
    if (((level[3] == 0 || level[4] == 0) && weighted == 0) || active >= cfg_wide)
      track_lost = 1'b1;
    in_window = (active >= 1 && active <= 2);
    if (!track_lost) begin
      if (weighted > 0) track_right = 1'b0;
      else if (weighted < 0) track_right = 1'b1;
      steer = weighted;
    end else begin
      if (in_window && level_sum >= int'(cfg_min_sum)) track_lost = 1'b0;
      if (!track_right) begin
        steer = int'(cfg_drive);
        if (level[0] != 0 && in_window) track_lost = 1'b0;
      end else begin
        steer = -int'(cfg_drive);
        if (level[7] != 0 && in_window) track_lost = 1'b0;
      end
    end
    r.steer_error   = steer[STEER_BITS-1:0];
    r.lost_line     = track_lost;
    r.heading_right = track_right;
    r.active_count  = active[COUNT_BITS-1:0];
    return r;
  endfunction

  function automatic sample_word_t lit_value();
    if (cfg_offset == 10'd1023) return FULL;
    return sample_word_t'($urandom_range(1023, int'(cfg_offset) + 1));
  endfunction

  function automatic sample_word_t dark_value();
    if ($urandom_range(0, 7) == 0) return cfg_offset;
    return sample_word_t'($urandom_range(int'(cfg_offset), 0));
  endfunction

  // mostly a line drifting across the array, plus dark, wide, edge and noise sets
  function automatic sample_t random_sensor_set();
    sample_word_t v [8];
    int kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) v[i] = dark_value();
    if (kind < 50) begin
      if ($urandom_range(0, 9) == 0) line_pos = $urandom_range(0, 7);
      else line_pos += $urandom_range(0, 2) - 1;
      if (line_pos < 0) line_pos = 0;
      if (line_pos > 7) line_pos = 7;
      v[line_pos] = lit_value();
      if ($urandom_range(0, 1) == 1 && line_pos < 7) v[line_pos + 1] = lit_value();
    end else if (kind < 70) begin
      if (kind >= 60) begin
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 3) != 0) v[i] = lit_value();
      end
    end else if (kind < 78) begin
      if ($urandom_range(0, 1) == 1) v[0] = lit_value();
      else v[7] = lit_value();
    end else begin
      for (int i = 0; i < 8; i++) v[i] = sample_word_t'($urandom);
    end
    return '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SENSOR_OFFSET:     cfg_offset  = data[OFFSET_BITS-1:0];
      REG_RECOVER_MIN_SUM:   cfg_min_sum = data[MIN_SUM_BITS-1:0];
      REG_WIDE_ACTIVE_COUNT: cfg_wide    = data[WIDE_BITS-1:0];
      REG_LOST_DRIVE:        cfg_drive   = data[DRIVE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ofs, input int min_sum, input int wide, input int drive);
    write_reg(REG_SENSOR_OFFSET, CFG_DATA_BITS'(ofs));
    write_reg(REG_RECOVER_MIN_SUM, CFG_DATA_BITS'(min_sum));
    write_reg(REG_WIDE_ACTIVE_COUNT, CFG_DATA_BITS'(wide));
    write_reg(REG_LOST_DRIVE, CFG_DATA_BITS'(drive));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_random(input int n);
    for (int i = 0; i < n; i++) sensor_sets.push_back(random_sensor_set());
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
    end while (sensor_sets.size() != 0 || sample_valid || steering_due.size() != 0);
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      if (gap_left > 0 || sensor_sets.size() == 0) begin
        if (gap_left > 0) gap_left--;
        sample_valid <= 1'b0;
      end else begin
        sample <= sensor_sets.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // result stall: modes of none, light, heavy and alternating
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(5, 60);
      end else begin
        stall_left--;
      end
      stall_tick++;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= stall_tick[0];
      endcase
    end
  end

  // monitor: check accepted results, then predict for accepted sets
  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_sensor_position_tracker_tb NOT OK");
      $finish;
    end
    if (rst) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_valid && !sample_stall;
      if (result_valid && !result_stall) begin
        if (steering_due.size() == 0) begin
          $error("result transaction with no set outstanding");
          mismatch_count++;
        end else begin
          want = steering_due.pop_front();
          if (result.steer_error !== want.steer_error) begin
            $error("steer_error: expected %0d, got %0d", want.steer_error, result.steer_error);
            mismatch_count++;
          end
          if (result.lost_line !== want.lost_line) begin
            $error("lost_line: expected %0d, got %0d", want.lost_line, result.lost_line);
            mismatch_count++;
          end
          if (result.heading_right !== want.heading_right) begin
            $error("heading_right: expected %0d, got %0d", want.heading_right,
                   result.heading_right);
            mismatch_count++;
          end
          if (result.active_count !== want.active_count) begin
            $error("active_count: expected %0d, got %0d", want.active_count,
                   result.active_count);
            mismatch_count++;
          end
        end
      end
      if (sample_valid && !sample_stall) steering_due.push_back(next_steering(sample));
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset settings: losing, edge and sum recovery, center cases, count limit
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL});
    sensor_sets.push_back(sample_t'{FULL, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{FULL, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, FULL});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{FULL, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, FULL, FULL, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, FULL, FULL, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, FULL, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, FULL});
    sensor_sets.push_back(sample_t'{FULL, FULL, FULL, FULL, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{FULL, FULL, FULL, FULL, FULL, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, FULL, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{AT_OFS, AT_OFS, AT_OFS, AT_OFS,
                                    AT_OFS, AT_OFS, AT_OFS, AT_OFS});
    sensor_sets.push_back(sample_t'{ABOVE, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO, ABOVE});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, FULL, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, FULL, FULL, FULL});
    add_random(90);
    wait_idle();

    // zero offset, count limit above eight: full-scale error both ways
    set_config(0, 8191, 15, 1023);
    sensor_sets.push_back(sample_t'{FULL, FULL, FULL, ZERO, ZERO, ZERO, ZERO, ZERO});
    sensor_sets.push_back(sample_t'{ZERO, ZERO, ZERO, ZERO, ZERO, FULL, FULL, FULL});
    sensor_sets.push_back(sample_t'{FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL});
    add_random(70);
    wait_idle();

    set_config(1023, 0, 1, 0);
    add_random(30);
    wait_idle();

    set_config(0, 0, 1, 0);
    add_random(60);
    wait_idle();

    set_config(512, 300, 3, 777);
    add_random(80);
    wait_idle();

    // zero count limit loses the line on every set
    set_config(100, 2000, 0, 1);
    add_random(40);
    wait_idle();

    set_config(950, 40, 8, 256);
    add_random(80);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      set_config($urandom_range(700, 1000), $urandom_range(0, 400), $urandom_range(2, 8),
                 $urandom_range(0, 1023));
      add_random(60);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("line_sensor_position_tracker_tb OK");
    end else begin
      $display("line_sensor_position_tracker_tb NOT OK");
    end
    $finish;
  end

endmodule
